// ===== src/wma_pkg.sv =====
// shared types and constants for the windowed moving average block
// no dependencies; used by wma_div and windowed_moving_average_core
package wma_pkg;

  // width of the window length register and the fill level field
  localparam int LEN_W = 9;

  // pass-through threshold is window length / FillDiv
  localparam int FillDiv = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_PUSH,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/wma_div.sv =====
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on wma_pkg for the status struct
module wma_div #(
  parameter int DVD_W = 25,
  parameter int DVS_W = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic [DVD_W-1:0]        quotient,
  output wma_pkg::div_stat_t      stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;

  logic [DVS_W:0]    shifted;
  logic              ge;
  logic [DVS_W:0]    diff;

  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== src/windowed_moving_average_core.sv =====
// Windowed moving average. Each transaction takes one signed sample, keeps it in a ring
// memory of MAX_WINDOW entries and updates a running sum and fill count; the result is the
// sum divided by the fill count (truncated toward zero), or the raw sample while the count
// is below window_length/8. Once the window is full a sample takes one memory read for
// the dropped sample, one write plus read of the oldest entry, then a one-bit-per-cycle
// divider; while the window is still filling the read for the dropped sample is skipped.
// A finished result waits in the output register while the next sample is accepted;
// in_ready returns in the cycle the result appears, so a new sample is taken only once the
// previous one is through, and later while the previous result still waits for out_ready.
// Writing cfg_wr_data restarts the window empty; 0 acts as 1 and values above MAX_WINDOW
// act as MAX_WINDOW.
// Depends on wma_pkg and wma_div.
module windowed_moving_average_core #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_result,
  output logic signed [SAMPLE_BITS-1:0] out_oldest_sample,
  output logic [wma_pkg::LEN_W-1:0]     out_fill_level,
  input  logic                          cfg_wr_en,
  input  logic [wma_pkg::LEN_W-1:0]     cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W + 1;
  localparam int WL_RST_I = (256 > MAX_WINDOW) ? MAX_WINDOW : 256;
  localparam logic [CNT_W-1:0] WL_RST   = CNT_W'(WL_RST_I);
  localparam logic [IDX_W-1:0] HEAD_TOP = IDX_W'(MAX_WINDOW - 1);

  wma_pkg::state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;

  logic [IDX_W-1:0]              head_r;
  logic [CNT_W-1:0]              held_r;
  logic [CNT_W-1:0]              wl_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic                          fwd_r;
  logic                          neg_r;
  logic                          raw_r;
  logic signed [SAMPLE_BITS-1:0] oldest_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_result_r;
  logic signed [SAMPLE_BITS-1:0] out_oldest_r;
  logic [CNT_W-1:0]              out_fill_r;

  logic                          mem_re;
  logic                          mem_we;
  logic                          div_start;
  logic                          out_load;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              head_inc;
  logic [CNT_W-1:0]              held_inc;
  logic [CNT_W-1:0]              wl_nxt;
  logic [SUM_W-1:0]              sum_abs;
  logic [SUM_W-1:0]              quotient;
  logic [SAMPLE_BITS-1:0]        q_mag;
  wma_pkg::div_stat_t            div_stat;
  logic                          full;

  // ring slot that lies cnt entries behind head
  function automatic logic [IDX_W-1:0] back_idx(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W:0] h;
    logic [CNT_W:0] c;
    logic [CNT_W:0] d;
    begin
      h = (CNT_W + 1)'(head);
      c = (CNT_W + 1)'(cnt);
      d = (h >= c) ? h - c : h + (CNT_W + 1)'(MAX_WINDOW) - c;
      back_idx = d[IDX_W-1:0];
    end
  endfunction

  always_comb begin
    full     = held_r >= wl_r;
    head_inc = (head_r == HEAD_TOP) ? '0 : head_r + 1'b1;
    held_inc = held_r + 1'b1;
    rd_addr  = (state_r == wma_pkg::ST_PUSH) ? back_idx(head_inc, held_inc)
                                              : back_idx(head_r, held_r);
    sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    q_mag    = quotient[SAMPLE_BITS-1:0];
    if (cfg_wr_data == '0) begin
      wl_nxt = CNT_W'(1);
    end else if (32'(cfg_wr_data) > MAX_WINDOW) begin
      wl_nxt = CNT_W'(MAX_WINDOW);
    end else begin
      wl_nxt = CNT_W'(cfg_wr_data);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wma_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = full ? wma_pkg::ST_DROP : wma_pkg::ST_PUSH;
        end
      end
      wma_pkg::ST_DROP: state_nxt = wma_pkg::ST_PUSH;
      wma_pkg::ST_PUSH: state_nxt = wma_pkg::ST_LOAD;
      wma_pkg::ST_LOAD: state_nxt = wma_pkg::ST_DIV;
      wma_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = wma_pkg::ST_DONE;
        end
      end
      wma_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      wma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_valid && full;
      end
      wma_pkg::ST_DROP: ;
      wma_pkg::ST_PUSH: begin
        mem_we = 1'b1;
        mem_re = 1'b1;
      end
      wma_pkg::ST_LOAD: div_start = 1'b1;
      wma_pkg::ST_DIV: ;
      wma_pkg::ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[head_r] <= samp_r;
    end
    if (mem_re) begin
      rd_data_r <= ring[rd_addr];
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
      sum_r  <= '0;
      wl_r   <= WL_RST;
    end else if (cfg_wr_en) begin
      wl_r   <= wl_nxt;
      held_r <= '0;
      sum_r  <= '0;
    end else begin
      priority case (1'b1)
        state_r == wma_pkg::ST_DROP: begin
          sum_r  <= sum_r - SUM_W'(rd_data_r);
          held_r <= held_r - 1'b1;
        end
        state_r == wma_pkg::ST_PUSH: begin
          sum_r  <= sum_r + SUM_W'(samp_r);
          held_r <= held_inc;
          head_r <= head_inc;
        end
        default: ;
      endcase
    end
  end

  // per-transaction payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp_r <= in_sample;
    end
    if (state_r == wma_pkg::ST_PUSH) begin
      // a fill count of one reads back the slot being written this cycle
      fwd_r <= held_inc == CNT_W'(1);
    end
    if (state_r == wma_pkg::ST_LOAD) begin
      oldest_r <= fwd_r ? samp_r : rd_data_r;
      neg_r    <= sum_r[SUM_W-1];
      raw_r    <= held_r < (wl_r / wma_pkg::FillDiv);
    end
  end

  wma_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_abs),
    .divisor  (held_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_r <= raw_r ? samp_r
                            : (neg_r ? SAMPLE_BITS'(-q_mag) : SAMPLE_BITS'(q_mag));
      out_oldest_r <= oldest_r;
      out_fill_r   <= held_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_oldest_sample = out_oldest_r;
  assign out_fill_level    = wma_pkg::LEN_W'(out_fill_r);

  a_held_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= wl_r)
    else $error("fill count above window length");

  a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r != '0)
    else $error("window length is zero");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == wma_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_wr_en) |=> state_r != wma_pkg::ST_IDLE)
    else $error("accepted transaction did not start");

endmodule
